// File: rtl/four_gamete_pair_search_top_defines.svh
// ----------------------------------------------------------------------------
// four gamete pair search assertion macros
// shared property wrappers for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef FOUR_GAMETE_PAIR_SEARCH_TOP_DEFINES_SVH
`define FOUR_GAMETE_PAIR_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FGPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FGPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fgps_pkg.sv
// ----------------------------------------------------------------------------
// fgps_pkg
// request and result types, codes and command/status structs of the
// four gamete pair search
// ----------------------------------------------------------------------------
package fgps_pkg;

  localparam int FIELD_IDX_W = 6;
  localparam int MAX_RESULTS = 64;
  localparam int K_W         = $clog2(MAX_RESULTS + 1);
  localparam int LOAD_W      = 128;

  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_SCAN   = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NO_ROW = 2'd2;

  // one bit per combination seen: 11, 10, 01, 00
  localparam logic [3:0] SEEN_11  = 4'h1;
  localparam logic [3:0] SEEN_10  = 4'h2;
  localparam logic [3:0] SEEN_01  = 4'h4;
  localparam logic [3:0] SEEN_00  = 4'h8;
  localparam logic [3:0] SEEN_ALL = 4'hF;

  localparam logic [2:0] ADDR_ALLELE_COUNT = 3'd0;
  localparam logic [2:0] ADDR_TWO_SET_MODE = 3'd4;
  localparam logic [7:0] ALLELE_COUNT_RST  = 8'd128;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] allele_low;
    logic [63:0] allele_high;
    logic [5:0]  row;
  } in_item_t;

  typedef struct packed {
    logic [5:0] row_index;
    logic [5:0] partner_index;
    logic       match_valid;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic finish;
    logic row_read;
    logic scan_init;
    logic scan_run;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       row_ok;
    logic       slot_free;
    logic       scan_done;
  } dp_sts_t;

endpackage

// File: rtl/fgps_ram.sv
// ----------------------------------------------------------------------------
// fgps_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module fgps_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low so a stalled compare keeps its operand
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/fgps_ctrl.sv
// ----------------------------------------------------------------------------
// fgps_ctrl
// sequencer for load, clear and scan requests
// ----------------------------------------------------------------------------
module fgps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fgps_pkg::dp_sts_t   sts,
  output fgps_pkg::ctrl_cmd_t cmd
);

  import fgps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_ROW   = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.kind == KIND_SCAN && sts.row_ok) begin
          cmd.row_read = 1'b1;
          state_nxt    = S_ROW;
        end else if (sts.slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_ROW: begin
        cmd.scan_init = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (sts.slot_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/fgps_dp.sv
// ----------------------------------------------------------------------------
// fgps_dp
// allele stores, entry counts, partner compare pipeline and result register
// ----------------------------------------------------------------------------
module fgps_dp #(
  parameter int DEPTH   = 64,
  parameter int STORE_W = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fgps_pkg::in_item_t   in_data,
  input  logic [7:0]           allele_count,
  input  logic                 two_set_mode,
  input  fgps_pkg::ctrl_cmd_t  cmd,
  output fgps_pkg::dp_sts_t    sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fgps_pkg::out_item_t  out_data
);

  import fgps_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > FIELD_IDX_W) ? CNT_W : FIELD_IDX_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [K_W-1:0]   K_MAX    = K_W'(MAX_RESULTS);
  localparam logic [7:0]       N_MAX    = 8'(STORE_W);

  // captured request
  logic [1:0]         kind_r;
  logic [5:0]         row_r;
  logic [STORE_W-1:0] word_r;

  logic [CNT_W-1:0]   cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0]   cnt_b_r, cnt_b_nxt;

  // scan state
  logic [STORE_W-1:0] row_vec_r;
  logic [STORE_W-1:0] mask_r, mask_nxt;
  logic               part_b_r;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic [CNT_W-1:0]   end_r;
  logic [K_W-1:0]     k_r, k_nxt;
  logic               pipe_v_r, pipe_v_nxt;
  logic [CNT_W-1:0]   pidx_r, pidx_nxt;
  logic               hold_v_r, hold_v_nxt;
  logic [CNT_W-1:0]   hidx_r, hidx_nxt;

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic [STORE_W-1:0] rdata_a, rdata_b, part;
  logic               we_a, we_b, re_a, re_b;
  logic [IDX_W-1:0]   raddr_a;
  logic               full_a, full_b, full_sel;
  logic               slot_free, issue, match, stall, adv;
  logic [3:0]         seen;
  logic [7:0]         n_eff;
  out_item_t          fin_item;

  assign full_a    = (cnt_a_r == CNT_FULL);
  assign full_b    = (cnt_b_r == CNT_FULL);
  assign full_sel  = (kind_r == KIND_LOAD_A) ? full_a : full_b;
  assign slot_free = !out_valid_r || out_ready;

  assign we_a = cmd.finish && (kind_r == KIND_LOAD_A) && !full_a;
  assign we_b = cmd.finish && (kind_r == KIND_LOAD_B) && !full_b;

  // four combination test on the partner held in the read register
  assign part = part_b_r ? rdata_b : rdata_a;
  always_comb begin
    seen = '0;
    if (|(row_vec_r & part & mask_r)) begin
      seen = seen | SEEN_11;
    end
    if (|(row_vec_r & ~part & mask_r)) begin
      seen = seen | SEEN_10;
    end
    if (|(~row_vec_r & part & mask_r)) begin
      seen = seen | SEEN_01;
    end
    if (|(~row_vec_r & ~part & mask_r)) begin
      seen = seen | SEEN_00;
    end
  end

  assign match = pipe_v_r && (seen == SEEN_ALL) && (k_r != K_MAX);
  // a new match needs the held one pushed out first
  assign stall = match && hold_v_r && !slot_free;
  assign adv   = !stall;
  assign issue = cmd.scan_run && adv && (j_r < end_r) && (k_r != K_MAX);

  assign re_a    = cmd.row_read || (issue && !part_b_r);
  assign re_b    = issue && part_b_r;
  assign raddr_a = cmd.row_read ? IDX_W'(row_r) : j_r[IDX_W-1:0];

  fgps_ram #(
    .DEPTH (DEPTH),
    .WIDTH (STORE_W)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[IDX_W-1:0]),
    .wdata (word_r),
    .re    (re_a),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  fgps_ram #(
    .DEPTH (DEPTH),
    .WIDTH (STORE_W)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[IDX_W-1:0]),
    .wdata (word_r),
    .re    (re_b),
    .raddr (j_r[IDX_W-1:0]),
    .rdata (rdata_b)
  );

  // compare mask from the clamped allele count
  always_comb begin
    n_eff = (allele_count > N_MAX) ? N_MAX : allele_count;
    for (int i = 0; i < STORE_W; i++) begin
      mask_nxt[i] = (8'(i) < n_eff);
    end
  end

  // single result of load, clear and unloaded row scan
  always_comb begin
    fin_item      = '0;
    fin_item.last = 1'b1;
    unique case (kind_r) inside
      KIND_LOAD_A, KIND_LOAD_B: begin
        if (full_sel) begin
          fin_item.status = ST_FULL;
        end else begin
          fin_item.row_index = (kind_r == KIND_LOAD_A) ? 6'(cnt_a_r) : 6'(cnt_b_r);
        end
      end
      KIND_SCAN: begin
        fin_item.row_index = row_r;
        fin_item.status    = ST_NO_ROW;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    if (cmd.finish) begin
      if (kind_r == KIND_CLEAR) begin
        cnt_a_nxt = '0;
        cnt_b_nxt = '0;
      end
      if (we_a) begin
        cnt_a_nxt = cnt_a_r + 1'b1;
      end
      if (we_b) begin
        cnt_b_nxt = cnt_b_r + 1'b1;
      end
    end
  end

  always_comb begin
    j_nxt      = j_r;
    k_nxt      = k_r;
    pipe_v_nxt = pipe_v_r;
    pidx_nxt   = pidx_r;
    hold_v_nxt = hold_v_r;
    hidx_nxt   = hidx_r;
    out_nxt    = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.scan_init) begin
      j_nxt      = two_set_mode ? '0 : CNT_W'(row_r) + 1'b1;
      k_nxt      = '0;
      pipe_v_nxt = 1'b0;
      hold_v_nxt = 1'b0;
    end

    if (cmd.scan_run && adv) begin
      pipe_v_nxt = issue;
      pidx_nxt   = j_r;
      if (issue) begin
        j_nxt = j_r + 1'b1;
      end
      if (match) begin
        k_nxt      = k_r + 1'b1;
        hold_v_nxt = 1'b1;
        hidx_nxt   = pidx_r;
        if (hold_v_r) begin
          out_valid_nxt         = 1'b1;
          out_nxt               = '0;
          out_nxt.row_index     = row_r;
          out_nxt.partner_index = 6'(hidx_r);
          out_nxt.match_valid   = 1'b1;
          out_nxt.status        = ST_OK;
        end
      end
    end

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      out_nxt       = fin_item;
    end

    // closing result of a scan: held match or no-match marker
    if (cmd.flush) begin
      out_valid_nxt       = 1'b1;
      out_nxt             = '0;
      out_nxt.row_index   = row_r;
      out_nxt.last        = 1'b1;
      out_nxt.status      = ST_OK;
      if (hold_v_r) begin
        out_nxt.partner_index = 6'(hidx_r);
        out_nxt.match_valid   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      pipe_v_r    <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      pipe_v_r    <= pipe_v_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_data.kind;
      row_r  <= in_data.row;
      word_r <= STORE_W'({in_data.allele_high, in_data.allele_low});
    end
    if (cmd.scan_init) begin
      row_vec_r <= rdata_a;
      mask_r    <= mask_nxt;
      part_b_r  <= two_set_mode;
      end_r     <= two_set_mode ? cnt_b_r : cnt_a_r;
    end
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    pidx_r <= pidx_nxt;
    hidx_r <= hidx_nxt;
    out_r  <= out_nxt;
  end

  assign sts.kind      = kind_r;
  assign sts.row_ok    = (CMP_W'(row_r) < CMP_W'(cnt_a_r));
  assign sts.slot_free = slot_free;
  assign sts.scan_done = ((j_r >= end_r) || (k_r == K_MAX)) && !pipe_v_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/four_gamete_pair_search_top.sv
// ----------------------------------------------------------------------------
// four_gamete_pair_search_top
// A load or clear request, and a scan of a row that was not loaded, gives its
// single result from the execute state once the result register is free. A
// scan of a loaded row reads the row in the execute state, sets up the scan
// in the row state and then compares one stored partner per cycle while
// nothing stalls it. The partner store has one read port, so P, the number of
// stored partners after the scanned row (single-set mode) or in set B
// (two-set mode), sets the scan length; fewer partners are compared once 64
// matches are found. The scan's closing result leaves from the flush state.
// After either result the next request is taken once the block is back in
// idle. A result register that is still full when a result is due holds the
// block until it drains: a match found while an earlier one still waits, the
// closing result and the single result alike. Only one request is in work at
// a time, and the result register lets the next request in while the last
// result waits. The stores come up undefined and are filled by loads only, so
// no clearing pass runs after reset.
// ----------------------------------------------------------------------------
`include "four_gamete_pair_search_top_defines.svh"

module four_gamete_pair_search_top #(
  parameter int DEPTH       = 64,
  parameter int ALLELE_BITS = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fgps_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fgps_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  import fgps_pkg::*;

  localparam int STORE_W = (ALLELE_BITS < LOAD_W) ? ALLELE_BITS : LOAD_W;

  logic [7:0] allele_count_r, allele_count_nxt;
  logic       two_set_mode_r, two_set_mode_nxt;
  logic       cfg_wr;
  logic [2:0] reg_addr;
  ctrl_cmd_t  cmd;
  dp_sts_t    sts;

  // register select ignores the byte lanes
  assign reg_addr = {paddr[2], 2'b00};
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;

  always_comb begin
    allele_count_nxt = allele_count_r;
    two_set_mode_nxt = two_set_mode_r;
    prdata           = '0;
    unique case (reg_addr)
      ADDR_ALLELE_COUNT: begin
        prdata = 32'(allele_count_r);
        if (cfg_wr) begin
          allele_count_nxt = pwdata[7:0];
        end
      end
      ADDR_TWO_SET_MODE: begin
        prdata = 32'(two_set_mode_r);
        if (cfg_wr) begin
          two_set_mode_nxt = pwdata[0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allele_count_r <= ALLELE_COUNT_RST;
      two_set_mode_r <= 1'b0;
    end else begin
      allele_count_r <= allele_count_nxt;
      two_set_mode_r <= two_set_mode_nxt;
    end
  end

  fgps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fgps_dp #(
    .DEPTH   (DEPTH),
    .STORE_W (STORE_W)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_data),
    .allele_count (allele_count_r),
    .two_set_mode (two_set_mode_r),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  // one request in work at a time
  `FGPS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "request accepted while busy")
  // only matches may be followed by more results of the same request
  `FGPS_ASSERT_NOW(a_nonlast_is_match, out_valid && !out_data.last,
    out_data.match_valid && out_data.status == ST_OK,
    "non-final result without a match")
  // error results always close their request
  `FGPS_ASSERT_NOW(a_error_is_last, out_valid && out_data.status != ST_OK,
    out_data.last && !out_data.match_valid, "error result not final")

endmodule
